// File: rtl/cms_pkg.sv
// Shared constants and helpers for the count-min sketch block.
package cms_pkg;
  localparam int MAX_ROWS_DEF     = 4;
  localparam int ROW_DEPTH_DEF    = 1024;
  localparam int KEY_BYTES_DEF    = 8;
  localparam int COUNTER_BITS_DEF = 32;
  localparam int SEED_REGS        = 4;
  localparam int CFG_IDX_BITS     = 3;
  localparam int CFG_DATA_BITS    = 32;
  localparam logic [63:0] SPOOKY_CONST = 64'hdeadbeefdeadbeef;

  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_WIDTH = 3'd1;
  localparam logic [2:0] REG_SEED0 = 3'd2;
  localparam logic [2:0] REG_SEED3 = 3'd5;

  // Rotate amounts of the eleven mixing steps of the short-message end.
  function automatic logic [5:0] mix_rot(input logic [3:0] i);
    case (i)
      4'd0:    mix_rot = 6'd15;
      4'd1:    mix_rot = 6'd52;
      4'd2:    mix_rot = 6'd26;
      4'd3:    mix_rot = 6'd51;
      4'd4:    mix_rot = 6'd28;
      4'd5:    mix_rot = 6'd9;
      4'd6:    mix_rot = 6'd47;
      4'd7:    mix_rot = 6'd54;
      4'd8:    mix_rot = 6'd32;
      4'd9:    mix_rot = 6'd25;
      default: mix_rot = 6'd63;
    endcase
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] k);
    rotl64 = (x << k) | (x >> (7'd64 - {1'b0, k}));
  endfunction
endpackage

// File: rtl/count_min_sketch_top.sv
// Top level of the count-min sketch: sequencer, counter memory, config registers.
// Usage: beats on the input channel carry action and flow_key under valid/stall.
// An update hashes the key once per row in use (SpookyHash, one row seed each) and
// bumps one saturating counter per row; a query returns the minimum of those
// counters as one estimate beat; a clear zeroes the whole counter memory.
// Per row: the shared hash unit runs its 11 mixing steps and is seen to finish, a
// shift-subtract divider reduces the hash modulo the effective row width (row_width
// clamped to 1..ROW_DEPTH), then one memory read and one read-modify-write follow.
// An update is ready for the next item, and a query shows its estimate beat, once
// its last row is done. A clear walks the memory one counter per cycle. The single
// hash unit, the divider and the one-port counter memory are shared by all rows,
// which are worked one after another.
// The input stall is high while an item is in work and while a result waits.
// Reset: registers take their reset values and a clearing pass zeroes the
// memory; no item is taken meanwhile, configuration writes are. When the
// receiver stalls the estimate beat holds and the block takes no new item
// until it is taken.
module count_min_sketch_top #(
  parameter int MAX_ROWS     = cms_pkg::MAX_ROWS_DEF,
  parameter int ROW_DEPTH    = cms_pkg::ROW_DEPTH_DEF,
  parameter int KEY_BYTES    = cms_pkg::KEY_BYTES_DEF,
  parameter int COUNTER_BITS = cms_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [63:0]                      flow_key,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      estimate,
  input  logic                             cfg_we,
  input  logic [cms_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [cms_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import cms_pkg::*;

  localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB = $clog2(ROW_DEPTH);
  localparam int AB = $clog2(MAX_ROWS * ROW_DEPTH);
  localparam int WB = $clog2(ROW_DEPTH + 1);
  localparam int DEPTH = MAX_ROWS * ROW_DEPTH;
  localparam logic [COUNTER_BITS-1:0] CMAX = '1;

  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_HASH = 3'd2, S_DIV = 3'd3,
                         S_READ = 3'd4, S_RMW = 3'd5, S_OUT = 3'd6;

  logic [2:0]  state;
  logic [2:0]  rows_in_use;
  logic [10:0] row_width;
  logic [31:0] seed [SEED_REGS];

  logic [1:0]  act;
  logic [63:0] key;
  logic [RB:0] row;
  logic [AB:0] clr_addr;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [5:0]  dcnt;
  logic        first;
  logic [COUNTER_BITS-1:0] best;
  logic [COUNTER_BITS-1:0] mem [DEPTH];
  logic [COUNTER_BITS-1:0] rd_data;
  logic [AB-1:0] addr;

  logic        h_start, h_done;
  logic [31:0] h_out;
  logic [RB:0] n_rows;
  logic [WB-1:0] width_eff;
  logic [RB:0] hash_row;
  logic [63:0] hash_key;
  logic [31:0] seed_sel;
  logic [32:0] trial;

  always_comb begin
    if (rows_in_use == 3'd0) n_rows = (RB+1)'(1);
    else if (32'(rows_in_use) > MAX_ROWS) n_rows = (RB+1)'(MAX_ROWS);
    else n_rows = (RB+1)'(rows_in_use);
    if (row_width == 11'd0) width_eff = WB'(1);
    else if (32'(row_width) > ROW_DEPTH) width_eff = WB'(ROW_DEPTH);
    else width_eff = WB'(row_width);
    // The hash starts in the cycle the item is taken or the previous row finishes, before
    // key and row are registered, so the next row and the incoming key are used.
    hash_row = (state == S_RMW) ? row + 1'b1 : '0;
    hash_key = (state == S_IDLE) ? flow_key : key;
    seed_sel = (32'(hash_row) < SEED_REGS) ? seed[hash_row[1:0]] : 32'd0;
    trial = {rem, quo[31]} - 33'(width_eff);
  end

  cms_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
    .clk(clk), .rst(rst), .start(h_start), .key(hash_key), .seed(seed_sel),
    .done(h_done), .hash(h_out)
  );

  assign h_start  = (state == S_IDLE && in_valid && !in_stall &&
                     (action == ACT_UPDATE || action == ACT_QUERY)) ||
                    (state == S_RMW && row + 1'b1 < n_rows);
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign estimate  = (COUNTER_BITS > 32 && |(64'(best) >> 32)) ? 32'hFFFFFFFF
                                                               : 32'(best);
  assign addr = AB'(row) * AB'(ROW_DEPTH) + AB'(rem[CB-1:0]);

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 3'd4;
      row_width   <= 11'd1024;
      for (int i = 0; i < SEED_REGS; i++) seed[i] <= 32'(i);
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) rows_in_use <= cfg_data[2:0];
      else if (cfg_index == REG_WIDTH) row_width <= cfg_data[10:0];
      else if (cfg_index >= REG_SEED0 && cfg_index <= REG_SEED3)
        seed[2'(cfg_index - REG_SEED0)] <= cfg_data;
    end
  end

  // Counter memory: one port, registered read.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) mem[clr_addr[AB-1:0]] <= '0;
    else if (state == S_RMW && act == ACT_UPDATE && rd_data != CMAX)
      mem[addr] <= rd_data + 1'b1;
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AB+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            act   <= action;
            key   <= flow_key;
            row   <= '0;
            first <= 1'b1;
            if (action == ACT_CLEAR) begin
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else if (action == ACT_UPDATE || action == ACT_QUERY) begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (h_done) begin
            quo   <= h_out;
            rem   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle; only the remainder is kept.
          quo <= {quo[30:0], 1'b0};
          if (!trial[32]) rem <= trial[31:0];
          else rem <= {rem[30:0], quo[31]};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd31) state <= S_READ;
        end
        S_READ: state <= S_RMW;
        S_RMW: begin
          if (first || rd_data < best) best <= rd_data;
          first <= 1'b0;
          if (row + 1'b1 < n_rows) begin
            row   <= row + 1'b1;
            state <= S_HASH;
          end else begin
            state <= (act == ACT_QUERY) ? S_OUT : S_IDLE;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/cms_hash.sv
// Iterative SpookyHash short-message unit: one mixing step per cycle.
module cms_hash #(
  parameter int KEY_BYTES = cms_pkg::KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  input  logic [31:0] seed,
  output logic        done,
  output logic [31:0] hash
);
  import cms_pkg::*;

  localparam logic [63:0] KEY_MASK = (KEY_BYTES >= 8) ? '1 :
                                     ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [63:0] LEN_WORD = 64'(KEY_BYTES) << 56;

  logic [63:0] a, b, c, d;
  logic [3:0]  step;
  logic        busy;
  logic [1:0]  sel;
  logic [63:0] x, y, z, z_rot, x_next;

  // The four words take turns: step i works on (x=word i+3, z=word i+2)
  // in the order d^=c, a^=d, b^=a, c^=b.
  assign sel = step[1:0];
  always_comb begin
    case (sel)
      2'd0:    begin x = d; z = c; end
      2'd1:    begin x = a; z = d; end
      2'd2:    begin x = b; z = a; end
      default: begin x = c; z = b; end
    endcase
    y      = '0;
    z_rot  = rotl64(z, mix_rot(step));
    x_next = (x ^ z) + z_rot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 4'd10) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= {32'd0, seed};
      b <= {32'd0, seed};
      c <= SPOOKY_CONST + (key & KEY_MASK);
      d <= SPOOKY_CONST + LEN_WORD;
    end else if (busy) begin
      case (sel)
        2'd0:    begin d <= x_next; c <= z_rot; end
        2'd1:    begin a <= x_next; d <= z_rot; end
        2'd2:    begin b <= x_next; a <= z_rot; end
        default: begin c <= x_next; b <= z_rot; end
      endcase
    end
  end

  assign hash = a[31:0] ^ 32'(y);
endmodule

// File: verif/count_min_sketch_top_test.sv
// Self-checking testbench of the count-min sketch block, with a counter-store predictor.
`timescale 1ns / 1ps

class sketch_scoreboard;
  logic [31:0] counters [0:4095];
  logic [2:0]  rows_reg;
  logic [10:0] width_reg;
  logic [31:0] seeds [0:3];
  logic [31:0] estimates_due [$];
  int          errors;

  function new();
    errors = 0;
    reset_state();
  endfunction

  function void reset_state();
    foreach (counters[i]) counters[i] = '0;
    rows_reg = 3'd4;
    width_reg = 11'd1024;
    for (int i = 0; i < 4; i++) seeds[i] = i;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    if (idx == cms_pkg::REG_ROWS) rows_reg = data[2:0];
    else if (idx == cms_pkg::REG_WIDTH) width_reg = data[10:0];
    else if (idx >= cms_pkg::REG_SEED0 && idx <= cms_pkg::REG_SEED3)
      seeds[idx - cms_pkg::REG_SEED0] = data;
  endfunction

  function logic [63:0] rot(logic [63:0] x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function logic [31:0] spooky_hash(logic [63:0] key, logic [31:0] seed);
    logic [63:0] a, b, c, d;
    a = {32'd0, seed};
    b = a;
    c = 64'hdeadbeefdeadbeef;
    d = c + (64'd8 << 56);
    c = c + key;
    d ^= c; c = rot(c, 15); d += c;
    a ^= d; d = rot(d, 52); a += d;
    b ^= a; a = rot(a, 26); b += a;
    c ^= b; b = rot(b, 51); c += b;
    d ^= c; c = rot(c, 28); d += c;
    a ^= d; d = rot(d, 9);  a += d;
    b ^= a; a = rot(a, 47); b += a;
    c ^= b; b = rot(b, 54); c += b;
    d ^= c; c = rot(c, 32); d += c;
    a ^= d; d = rot(d, 25); a += d;
    b ^= a; a = rot(a, 63); b += a;
    return a[31:0];
  endfunction

  function int counter_slot(int row, logic [63:0] key);
    int w;
    w = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
    return row * 1024 + (spooky_hash(key, seeds[row]) % w);
  endfunction

  function void note_item(logic [1:0] act, logic [63:0] key);
    int n, idx;
    logic [31:0] lowest;
    n = (rows_reg == 0) ? 1 : (rows_reg > 4) ? 4 : rows_reg;
    lowest = '0;
    if (act == cms_pkg::ACT_UPDATE) begin
      for (int r = 0; r < n; r++) begin
        idx = counter_slot(r, key);
        if (counters[idx] != 32'hffffffff) counters[idx]++;
      end
    end else if (act == cms_pkg::ACT_QUERY) begin
      for (int r = 0; r < n; r++) begin
        idx = counter_slot(r, key);
        if (r == 0 || counters[idx] < lowest) lowest = counters[idx];
      end
      estimates_due.push_back(lowest);
    end else if (act == cms_pkg::ACT_CLEAR) begin
      foreach (counters[i]) counters[i] = '0;
    end
  endfunction

  function void check_estimate(logic [31:0] got);
    logic [31:0] want;
    if (estimates_due.size() == 0) begin
      $error("estimate beat with nothing expected: %h", got);
      errors++;
      return;
    end
    want = estimates_due.pop_front();
    if (got !== want) begin
      $error("estimate mismatch: expected %h actual %h", want, got);
      errors++;
    end
  endfunction
endclass

module count_min_sketch_top_test;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = cms_pkg::ACT_UPDATE;
  logic [63:0] flow_key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] estimate;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = cms_pkg::REG_ROWS;
  logic [31:0] cfg_data = '0;

  sketch_scoreboard sb = new();
  longint cycle_count = 0;
  logic   stall_mode = 1'b0;
  logic [63:0] key_pool [0:7];

  count_min_sketch_top uut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd3000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_item(action, flow_key);
    if (!rst && out_valid && !out_stall) sb.check_estimate(estimate);
  end

  // The receiver alternates between quiet stretches and heavy random stalling.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic wait_idle();
    while (sb.estimates_due.size() != 0) @(negedge clk);
    // An update or clear may still be in work with nothing expected.
    repeat (4200) @(negedge clk);
  endtask

  // Drives one beat and holds it until taken; a further beat follows without a gap.
  task automatic send_item(logic [1:0] act, logic [63:0] key);
    action <= act;
    flow_key <= key;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    int burst;
    logic [1:0] act;
    logic [63:0] key;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && count > 0; i++) begin
        case ($urandom_range(0, 99)) inside
          [0:54]:  act = cms_pkg::ACT_UPDATE;
          [55:96]: act = cms_pkg::ACT_QUERY;
          [97:98]: act = 2'd3;
          default: act = cms_pkg::ACT_CLEAR;
        endcase
        key = $urandom_range(0, 2) != 0 ? key_pool[$urandom_range(0, 7)]
                                        : {$urandom, $urandom};
        send_item(act, key);
        count--;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(0, 40));
    end
    pause(0);
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    sb.reset_state();

    // Directed: field extremes, every action, out-of-range registers.
    send_item(cms_pkg::ACT_QUERY, 64'd0);
    send_item(cms_pkg::ACT_UPDATE, 64'd0);
    send_item(cms_pkg::ACT_UPDATE, '1);
    send_item(cms_pkg::ACT_UPDATE, 64'h5555_5555_aaaa_aaaa);
    send_item(cms_pkg::ACT_QUERY, 64'd0);
    send_item(cms_pkg::ACT_QUERY, '1);
    send_item(2'd3, 64'h1234);
    send_item(cms_pkg::ACT_QUERY, 64'h5555_5555_aaaa_aaaa);
    send_item(cms_pkg::ACT_CLEAR, '1);
    send_item(cms_pkg::ACT_QUERY, '1);
    pause(0);
    wait_idle();
    write_reg(cms_pkg::REG_ROWS, 32'd0);
    write_reg(cms_pkg::REG_WIDTH, 32'd0);
    // Width zero acts as width one and puts every key on one counter per row.
    send_item(cms_pkg::ACT_UPDATE, 64'd7);
    send_item(cms_pkg::ACT_UPDATE, 64'd9);
    send_item(cms_pkg::ACT_QUERY, '1);
    pause(0);
    wait_idle();
    write_reg(cms_pkg::REG_ROWS, 32'd7);
    write_reg(cms_pkg::REG_WIDTH, 32'h7ff);
    write_reg(cms_pkg::REG_SEED0, 32'hffffffff);
    write_reg(cms_pkg::REG_SEED0 + 3'd1, 32'd0);
    write_reg(cms_pkg::REG_SEED0 + 3'd2, 32'h8000_0001);
    write_reg(cms_pkg::REG_SEED3, 32'hdead_beef);
    // Width changed without a clear leaves old counts in place.
    send_item(cms_pkg::ACT_QUERY, 64'd7);
    send_item(cms_pkg::ACT_UPDATE, 64'd7);
    send_item(cms_pkg::ACT_QUERY, 64'd7);
    pause(0);

    random_phase(200);
    wait_idle();
    write_reg(cms_pkg::REG_ROWS, 32'd1);
    write_reg(cms_pkg::REG_WIDTH, 32'd3);
    write_reg(cms_pkg::REG_SEED0, $urandom);
    random_phase(150);
    wait_idle();
    write_reg(cms_pkg::REG_ROWS, 32'd3);
    write_reg(cms_pkg::REG_WIDTH, 32'd1024);
    for (int i = 0; i < 4; i++) write_reg(3'(cms_pkg::REG_SEED0 + i), $urandom);
    random_phase(150);
    wait_idle();
    write_reg(cms_pkg::REG_ROWS, 32'd4);
    write_reg(cms_pkg::REG_WIDTH, 32'd17);
    random_phase(200);

    wait_idle();
    if (sb.errors == 0 && sb.estimates_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (sb.estimates_due.size() != 0)
        $error("estimates left over: %0d", sb.estimates_due.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/cms_pkg.sv
rtl/cms_hash.sv
rtl/count_min_sketch_top.sv
verif/count_min_sketch_top_test.sv
